// ===== rtl/rhsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsr_pkg: shared constants for the RGB half-scale / rotate block
// Register indexes, command codes and field widths used by the ports.
// ----------------------------------------------------------------------------
package rhsr_pkg;

  // Field widths
  localparam int unsigned CH_W     = 8;   // one color channel
  localparam int unsigned QTR_W    = 6;   // channel divided by four
  localparam int unsigned PAIR_W   = 7;   // sum of two quarters
  localparam int unsigned DIM_W    = 7;   // rows_in / cols_in registers
  localparam int unsigned CFG_IDX_W = 2;  // configuration register index
  localparam int unsigned CFG_DAT_W = 7;  // configuration write data

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP    = 2'd2;

  // Request command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [DIM_W-1:0] COLS_RESET = 7'd64;

endpackage : rhsr_pkg

// ===== rtl/rgb_half_scale_with_rotate_top.sv =====
// ----------------------------------------------------------------------------
// rgb_half_scale_with_rotate_top: 2x2 box downsample with optional rotation
// Halves an RGB raster image; in flip mode stores the blocks and plays them
// back last-first so the half-size image comes out rotated 180 degrees.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start_i while busy_o is low (busy_o is never raised).
//   command_i = pixel carries one raster pixel on red_i/green_i/blue_i;
//   command_i = drain asks for one stored block in flip mode.
//   Configuration: cfg_valid_i/cfg_ready_o write rows_in, cols_in or flip by
//   cfg_index_i; a write to any of these three restarts the frame. Write only while idle.
//   Results: out_valid_o strobes for one cycle with red_out_o, green_out_o,
//   blue_out_o and frame_last_o. The receiver cannot stall the block.
// Timing:
//   One request per cycle, every cycle. A result appears in the cycle after the
//   request that causes it: the pixel closing a 2x2 block in plain mode, or a
//   drain once the whole flipped frame is stored. The line-sum memory is read
//   on the left pixel of each lower pair, so the right pixel finds its upper
//   sums already registered; the block store read is one registered port.
// Reset:
//   Counters and config return to defaults; memories are not cleared and need
//   no clearing pass, since nothing reads an entry before it is written.
// ----------------------------------------------------------------------------
module rgb_half_scale_with_rotate_top #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           command_i,
  input  logic [rhsr_pkg::CH_W-1:0]      red_i,
  input  logic [rhsr_pkg::CH_W-1:0]      green_i,
  input  logic [rhsr_pkg::CH_W-1:0]      blue_i,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rhsr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rhsr_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // result channel
  output logic                           out_valid_o,
  output logic [rhsr_pkg::CH_W-1:0]      red_out_o,
  output logic [rhsr_pkg::CH_W-1:0]      green_out_o,
  output logic [rhsr_pkg::CH_W-1:0]      blue_out_o,
  output logic                           frame_last_o
);
  import rhsr_pkg::*;

  localparam int unsigned HALF_COLS   = MAX_COLS / 2;
  localparam int unsigned STORE_DEPTH = (MAX_ROWS / 2) * (MAX_COLS / 2);
  localparam int unsigned RW  = $clog2(MAX_ROWS);        // row counter
  localparam int unsigned CW  = $clog2(MAX_COLS);        // column counter
  localparam int unsigned RDW = $clog2(MAX_ROWS + 1);    // clamped rows
  localparam int unsigned CDW = $clog2(MAX_COLS + 1);    // clamped cols
  localparam int unsigned LSW = (HALF_COLS > 1) ? $clog2(HALF_COLS) : 1;
  localparam int unsigned SCW = $clog2(STORE_DEPTH + 1); // stored count
  localparam int unsigned SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LINE_W = 3 * PAIR_W;
  localparam int unsigned BLK_W  = 3 * CH_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] rows_in_q, cols_in_q;
  logic             flip_q;
  logic             cfg_wr, cfg_hit;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_wr && ((cfg_index_i == REG_ROWS_IN) ||
                                  (cfg_index_i == REG_COLS_IN) ||
                                  (cfg_index_i == REG_FLIP));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_in_q <= ROWS_RESET;
      cols_in_q <= COLS_RESET;
      flip_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_ROWS_IN: rows_in_q <= cfg_data_i;
        REG_COLS_IN: cols_in_q <= cfg_data_i;
        REG_FLIP:    flip_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame geometry: clamp dimensions, block counts
  // --------------------------------------------------------------------------
  logic [RDW-1:0] rows_c;
  logic [CDW-1:0] cols_c;
  logic [RDW-1:0] brows;
  logic [CDW-1:0] bcols;
  logic [SCW-1:0] total;
  logic           roff, coff;

  always_comb begin
    if (rows_in_q < DIM_W'(2))                  rows_c = RDW'(2);
    else if (32'(rows_in_q) > 32'(MAX_ROWS))    rows_c = RDW'(MAX_ROWS);
    else                                        rows_c = RDW'(rows_in_q);
    if (cols_in_q < DIM_W'(2))                  cols_c = CDW'(2);
    else if (32'(cols_in_q) > 32'(MAX_COLS))    cols_c = CDW'(MAX_COLS);
    else                                        cols_c = CDW'(cols_in_q);
  end

  assign brows = rows_c >> 1;
  assign bcols = cols_c >> 1;
  assign total = SCW'(brows) * SCW'(bcols);
  assign roff  = flip_q & rows_c[0];
  assign coff  = flip_q & cols_c[0];

  // --------------------------------------------------------------------------
  // Position and window decode for the incoming pixel
  // --------------------------------------------------------------------------
  logic [RW-1:0] row_q, row_d, rr;
  logic [CW-1:0] col_q, col_d, cc;
  logic          accept, is_pixel, is_drain;
  logic          frame_start, in_win;
  logic          col_odd, row_odd, blk_done, plain_last;
  logic [LSW-1:0] bc;

  assign accept      = start_i && !busy_o;
  assign is_pixel    = accept && (command_i == CMD_PIXEL);
  assign is_drain    = accept && (command_i == CMD_DRAIN);
  assign frame_start = (row_q == '0) && (col_q == '0);

  assign rr = row_q - RW'(roff);
  assign cc = col_q - CW'(coff);
  assign in_win = (row_q >= RW'(roff)) && (col_q >= CW'(coff)) &&
                  (32'(rr) < 32'(brows) * 32'd2) &&
                  (32'(cc) < 32'(bcols) * 32'd2);
  assign col_odd    = cc[0];
  assign row_odd    = rr[0];
  assign bc         = LSW'(cc >> 1);
  assign blk_done   = is_pixel && in_win && col_odd && row_odd;
  assign plain_last = (32'(rr >> 1) == 32'(brows) - 32'd1) &&
                      (32'(cc >> 1) == 32'(bcols) - 32'd1);

  // Raster counters, wrapping at the clamped frame size
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (32'(col_q) + 32'd1 >= 32'(cols_c)) begin
      col_d = '0;
      if (32'(row_q) + 32'd1 >= 32'(rows_c)) row_d = '0;
      else                                   row_d = row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Quarter sums: left pixel of a pair, pair sum, block sum
  // --------------------------------------------------------------------------
  logic [QTR_W-1:0]  q_r, q_g, q_b;
  logic [QTR_W-1:0]  hold_r_q, hold_g_q, hold_b_q;
  logic [PAIR_W-1:0] pair_r, pair_g, pair_b;
  logic [LINE_W-1:0] line_rd_q;
  logic [CH_W-1:0]   blk_r, blk_g, blk_b;

  assign q_r = QTR_W'(red_i   >> 2);
  assign q_g = QTR_W'(green_i >> 2);
  assign q_b = QTR_W'(blue_i  >> 2);

  assign pair_r = PAIR_W'(hold_r_q) + PAIR_W'(q_r);
  assign pair_g = PAIR_W'(hold_g_q) + PAIR_W'(q_g);
  assign pair_b = PAIR_W'(hold_b_q) + PAIR_W'(q_b);

  assign blk_r = CH_W'(line_rd_q[3*PAIR_W-1:2*PAIR_W]) + CH_W'(pair_r);
  assign blk_g = CH_W'(line_rd_q[2*PAIR_W-1:PAIR_W])   + CH_W'(pair_g);
  assign blk_b = CH_W'(line_rd_q[PAIR_W-1:0])          + CH_W'(pair_b);

  // Left pixel of each pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_r_q <= '0;
      hold_g_q <= '0;
      hold_b_q <= '0;
    end else if (cfg_hit) begin
      hold_r_q <= '0;
      hold_g_q <= '0;
      hold_b_q <= '0;
    end else if (is_pixel && in_win && !col_odd) begin
      hold_r_q <= q_r;
      hold_g_q <= q_g;
      hold_b_q <= q_b;
    end
  end

  // Line-sum memory: upper pair written on even rows, read ahead on the
  // left pixel of the lower pair
  logic [LINE_W-1:0] line_mem [HALF_COLS];

  always_ff @(posedge clk_i) begin
    if (is_pixel && in_win && col_odd && !row_odd) begin
      line_mem[bc] <= {pair_r, pair_g, pair_b};
    end
    if (is_pixel && in_win && !col_odd && row_odd) begin
      line_rd_q <= line_mem[bc];
    end
  end

  // --------------------------------------------------------------------------
  // Block store and drain control (flip mode)
  // --------------------------------------------------------------------------
  logic [SCW-1:0] stored_q, stored_d, sc_eff;
  logic [SCW-1:0] drain_q, drain_d;
  logic [SCW-1:0] rd_idx;
  logic           drain_ok, store_wr;
  logic [BLK_W-1:0] blk_mem [STORE_DEPTH];
  logic [BLK_W-1:0] mem_rd_q;

  assign sc_eff   = frame_start ? '0 : stored_q;
  assign store_wr = blk_done && flip_q && (32'(sc_eff) < 32'(STORE_DEPTH));
  assign drain_ok = is_drain && flip_q && (stored_q == total) &&
                    (drain_q < stored_q);
  assign rd_idx   = stored_q - SCW'(1) - drain_q;

  always_comb begin
    stored_d = stored_q;
    drain_d  = drain_q;
    if (drain_ok) begin
      drain_d = drain_q + SCW'(1);
    end else if (is_pixel) begin
      stored_d = store_wr ? sc_eff + SCW'(1) : sc_eff;
      if (frame_start) drain_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      blk_mem[sc_eff[SAW-1:0]] <= {blk_r, blk_g, blk_b};
    end
    if (drain_ok) begin
      mem_rd_q <= blk_mem[rd_idx[SAW-1:0]];
    end
  end

  // Counters: a config write to rows_in, cols_in or flip restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      stored_q <= '0;
      drain_q  <= '0;
    end else if (cfg_hit) begin
      row_q    <= '0;
      col_q    <= '0;
      stored_q <= '0;
      drain_q  <= '0;
    end else begin
      stored_q <= stored_d;
      drain_q  <= drain_d;
      if (is_pixel) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic             out_valid_q, out_mem_q, out_last_q;
  logic [BLK_W-1:0] blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_mem_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= drain_ok || (blk_done && !flip_q);
      out_mem_q   <= drain_ok;
      out_last_q  <= drain_ok ? (drain_q + SCW'(1) == total) : plain_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_done && !flip_q) begin
      blk_q <= {blk_r, blk_g, blk_b};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_last_o = out_valid_q && out_last_q;
  assign red_out_o    = out_mem_q ? mem_rd_q[3*CH_W-1:2*CH_W] : blk_q[3*CH_W-1:2*CH_W];
  assign green_out_o  = out_mem_q ? mem_rd_q[2*CH_W-1:CH_W]   : blk_q[2*CH_W-1:CH_W];
  assign blue_out_o   = out_mem_q ? mem_rd_q[CH_W-1:0]        : blk_q[CH_W-1:0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a result always follows a request from the previous cycle
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start_i && !busy_o))
    else $error("result without a request");

  // drain pointer never passes the number of stored blocks
  a_drain_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_q <= stored_q) && (32'(stored_q) <= 32'(STORE_DEPTH)))
    else $error("drain index or store count out of range");

  // the last drained block exhausts the store
  a_last_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_last_o && out_mem_q) |-> (drain_q == stored_q))
    else $error("frame end flagged with blocks left");

  // plain mode never writes the block store
  a_plain_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flip_q |-> !store_wr)
    else $error("block store written in plain mode");
`endif

endmodule : rgb_half_scale_with_rotate_top

// ===== sim/tb_rgb_half_scale_with_rotate_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_half_scale_with_rotate_top: testbench for the RGB half-scale block
// Sends pixel and drain requests with random gaps, rewrites the frame size
// and flip mode between phases, keeps its own copy of the 2x2 downsampler
// and compares every output pixel, field by field, in order.
// ----------------------------------------------------------------------------
module tb_rgb_half_scale_with_rotate_top;
  import rhsr_pkg::*;

  localparam int unsigned MAX_ROWS     = 64;
  localparam int unsigned MAX_COLS     = 64;
  localparam int unsigned HALF_COLS    = MAX_COLS / 2;
  localparam int unsigned STORE_DEPTH  = (MAX_ROWS / 2) * (MAX_COLS / 2);
  localparam int unsigned ITEM_TARGET  = 1300;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t px;
    logic last;
  } out_pixel_t;

  // Downsampler copy plus the queue of output pixels still to come
  class halfscale_scoreboard;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic             flip_reg;
    logic [5:0]       row_pos;
    logic [5:0]       col_pos;
    rgb_t             pair_hold;
    rgb_t             line_sums [HALF_COLS];
    rgb_t             block_store [STORE_DEPTH];
    logic [10:0]      stored_count;
    logic [10:0]      drained_count;
    out_pixel_t       pending_pixels [$];
    int unsigned      errors;

    function new();
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      flip_reg = 1'b0;
      errors   = 0;
      restart_frame();
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function rgb_t add_rgb(rgb_t a, rgb_t b);
      rgb_t s;
      s.red   = a.red + b.red;
      s.green = a.green + b.green;
      s.blue  = a.blue + b.blue;
      return s;
    endfunction

    function void restart_frame();
      row_pos       = '0;
      col_pos       = '0;
      pair_hold     = '0;
      stored_count  = '0;
      drained_count = '0;
    endfunction

    // any write to a real register starts a new frame
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_ROWS_IN: rows_reg = data;
        REG_COLS_IN: cols_reg = data;
        REG_FLIP:    flip_reg = data[0];
        default:     return;
      endcase
      restart_frame();
    endfunction

    function void note_request(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                               logic [CH_W-1:0] b);
      int unsigned rows, cols, brows, bcols, total, roff, coff;
      int unsigned row, col, rr, cc, bc;
      rgb_t        q, pair, blk;
      out_pixel_t  e;
      rows  = clamp_dim(rows_reg, MAX_ROWS);
      cols  = clamp_dim(cols_reg, MAX_COLS);
      brows = rows / 2;
      bcols = cols / 2;
      total = brows * bcols;
      roff  = flip_reg ? rows % 2 : 0;
      coff  = flip_reg ? cols % 2 : 0;

      // drain: only in flip mode, once the frame is fully stored, last block first
      if (cmd == CMD_DRAIN) begin
        if (flip_reg && stored_count == total && drained_count < stored_count) begin
          blk = block_store[stored_count - 1 - drained_count];
          drained_count++;
          e.px   = blk;
          e.last = (drained_count == total);
          pending_pixels.push_back(e);
        end
        return;
      end

      row = row_pos;
      col = col_pos;
      if (row == 0 && col == 0) begin
        stored_count  = '0;
        drained_count = '0;
      end

      // pixels outside the paired area only move the position
      if (row >= roff && col >= coff && row - roff < 2 * brows && col - coff < 2 * bcols) begin
        rr = row - roff;
        cc = col - coff;
        bc = cc / 2;
        q.red   = r >> 2;
        q.green = g >> 2;
        q.blue  = b >> 2;
        if (cc % 2 == 0) begin
          pair_hold = q;
        end else begin
          pair = add_rgb(pair_hold, q);
          if (rr % 2 == 0) begin
            line_sums[bc] = pair;
          end else begin
            blk = add_rgb(line_sums[bc], pair);
            if (!flip_reg) begin
              e.px   = blk;
              e.last = (rr / 2 == brows - 1) && (bc == bcols - 1);
              pending_pixels.push_back(e);
            end else if (stored_count < STORE_DEPTH) begin
              block_store[stored_count] = blk;
              stored_count++;
            end
          end
        end
      end

      col++;
      if (col >= cols) begin
        col = 0;
        row++;
        if (row >= rows) row = 0;
      end
      row_pos = 6'(row);
      col_pos = 6'(col);
    endfunction

    function void compare_field(string name, logic [CH_W-1:0] exp, logic [CH_W-1:0] act);
      if (act !== exp) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                              logic last);
      out_pixel_t e;
      if (pending_pixels.size() == 0) begin
        $display("%0t: output pixel %0d %0d %0d last %0b with none expected",
                 $time, r, g, b, last);
        errors++;
        return;
      end
      e = pending_pixels.pop_front();
      compare_field("red_out", e.px.red, r);
      compare_field("green_out", e.px.green, g);
      compare_field("blue_out", e.px.blue, b);
      compare_field("frame_last", CH_W'(e.last), CH_W'(last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  logic                 command_i   = CMD_PIXEL;
  logic [CH_W-1:0]      red_i       = '0;
  logic [CH_W-1:0]      green_i     = '0;
  logic [CH_W-1:0]      blue_i      = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_ROWS_IN;
  logic [CFG_DAT_W-1:0] cfg_data_i  = '0;
  logic                 out_valid_o;
  logic [CH_W-1:0]      red_out_o;
  logic [CH_W-1:0]      green_out_o;
  logic [CH_W-1:0]      blue_out_o;
  logic                 frame_last_o;

  halfscale_scoreboard sb = new();

  // stimulus-side view of the configuration
  logic [DIM_W-1:0] cur_rows = ROWS_RESET;
  logic [DIM_W-1:0] cur_cols = COLS_RESET;
  logic             cur_flip = 1'b0;
  int unsigned      items_sent = 0;
  bit               gaps_on = 1'b0;

  rgb_half_scale_with_rotate_top #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .command_i   (command_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_last_o(frame_last_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor: config writes, accepted requests and output pixels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (start_i && !busy_o) sb.note_request(command_i, red_i, green_i, blue_i);
      if ($isunknown(out_valid_o)) begin
        $display("%0t: out_valid_o expected 0 or 1, got %b", $time, out_valid_o);
        sb.errors++;
      end
      if (out_valid_o === 1'b1)
        sb.check_pixel(red_out_o, green_out_o, blue_out_o, frame_last_o);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(bit allow_big);
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 7'($urandom_range(0, 2));
    if (pick == 1 && allow_big) begin
      case ($urandom_range(0, 3))
        0:       return 7'd63;
        1:       return 7'd64;
        2:       return 7'd65;
        default: return 7'd127;
      endcase
    end
    return 7'($urandom_range(2, 9));
  endfunction

  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // one request; start_i stays high for a back-to-back follower
  task automatic send_request(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                              logic [CH_W-1:0] b);
    idle_gap();
    start_i   <= 1'b1;
    command_i <= cmd;
    red_i     <= r;
    green_i   <= g;
    blue_i    <= b;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    items_sent++;
  endtask

  task automatic send_pixels(int unsigned n, bit noisy);
    repeat (n) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_request(CMD_DRAIN, rand_chan(), rand_chan(), rand_chan());
      send_request(CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  task automatic send_drains(int unsigned n);
    repeat (n) send_request(CMD_DRAIN, rand_chan(), rand_chan(), rand_chan());
  endtask

  // drop start and let every expected pixel come out
  task automatic wait_idle();
    start_i <= 1'b0;
    for (int i = 0; i < 64 && sb.pending_pixels.size() != 0; i++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  // mask bits: rows, cols, flip
  task automatic configure(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                           logic [CFG_DAT_W-1:0] flip_data, logic [2:0] mask);
    wait_idle();
    if (mask == 3'b000) mask = 3'b111;
    if (mask[0]) begin
      write_reg(REG_ROWS_IN, rows);
      cur_rows = rows;
    end
    if (mask[1]) begin
      write_reg(REG_COLS_IN, cols);
      cur_cols = cols;
    end
    if (mask[2]) begin
      write_reg(REG_FLIP, flip_data);
      cur_flip = flip_data[0];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  initial begin
    int unsigned eff_rows, eff_cols, frame_px, blocks;
    logic [DIM_W-1:0] new_rows, new_cols;
    logic [2:0]       cfg_mask;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config is 64x64 plain: a partial top row and a drain give nothing
    send_request(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
    send_request(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
    send_request(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    // write to the spare index must not restart the frame
    wait_idle();
    write_reg(REG_SPARE, 7'h7F);
    cfg_valid_i <= 1'b0;
    send_request(CMD_PIXEL, 8'h80, 8'h7F, 8'h01);

    // 2x2 plain: full-scale red/blue, green rounds down to zero
    configure(7'd2, 7'd2, 7'd0, 3'b111);
    send_request(CMD_PIXEL, 8'hFF, 8'h03, 8'hFF);
    send_request(CMD_PIXEL, 8'hFF, 8'h03, 8'hFF);
    send_request(CMD_PIXEL, 8'hFF, 8'h03, 8'hFF);
    send_request(CMD_PIXEL, 8'hFF, 8'h03, 8'hFF);
    send_request(CMD_DRAIN, 8'h00, 8'h00, 8'h00);

    // 3x3 flip: drain too early, mid-frame drain, one block, then exhausted
    configure(7'd3, 7'd3, 7'h7F, 3'b111);
    send_request(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    send_pixels(5, 1'b0);
    send_request(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    send_pixels(4, 1'b0);
    send_drains(2);

    // random phases of well-formed frames, some broken, some noise
    while (items_sent + 250 < ITEM_TARGET) begin
      cfg_mask = 3'($urandom_range(0, 7));
      if (cfg_mask == 3'b000) cfg_mask = 3'b111;
      // a large dimension only while the other one stays small
      new_rows = pick_dim(cfg_mask[1] ||
                          (halfscale_scoreboard::clamp_dim(cur_cols, MAX_COLS) <= 9));
      new_cols = pick_dim(halfscale_scoreboard::clamp_dim(cfg_mask[0] ? new_rows : cur_rows,
                                                          MAX_ROWS) <= 9);
      configure(new_rows, new_cols, 7'($urandom_range(0, 127)), cfg_mask);
      gaps_on  = (items_sent + 450 < ITEM_TARGET) && ($urandom_range(0, 3) != 0);
      eff_rows = halfscale_scoreboard::clamp_dim(cur_rows, MAX_ROWS);
      eff_cols = halfscale_scoreboard::clamp_dim(cur_cols, MAX_COLS);
      frame_px = eff_rows * eff_cols;
      blocks   = (eff_rows / 2) * (eff_cols / 2);
      repeat ($urandom_range(1, 3)) begin
        if (items_sent + 250 >= ITEM_TARGET) break;
        if ($urandom_range(0, 9) == 0) begin
          // broken frame: stops short, the next frame starts mid-way
          send_pixels($urandom_range(1, frame_px - 1), 1'b1);
        end else begin
          send_pixels(frame_px, $urandom_range(0, 3) == 0);
          if (cur_flip) begin
            // sometimes leave blocks unread so the next frame drops them
            if ($urandom_range(0, 7) == 0) send_drains($urandom_range(0, blocks));
            else send_drains(blocks + $urandom_range(0, 2));
          end else if ($urandom_range(0, 7) == 0) begin
            send_drains($urandom_range(1, 2));
          end
        end
      end
    end

    // tall flipped frame with an odd width, no gaps from here on
    gaps_on = 1'b0;
    configure(7'd64, 7'd3, 7'd1, 3'b111);
    send_pixels(MAX_ROWS * 3, 1'b0);
    send_drains((MAX_ROWS / 2) + 1);

    // drain the pipeline and report
    start_i <= 1'b0;
    for (int i = 0; i < 200 && sb.pending_pixels.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.pending_pixels.size() != 0)
      $display("%0t: %0d expected output pixels never arrived",
               $time, sb.pending_pixels.size());
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("%0t: timeout", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule
